// ===== rtl/fsq_pkg.sv =====
// Shared types, codes and constants for the frame script sequencer.
package fsq_pkg;

  // Default sizes
  localparam int MaxCommandsDefault = 32;
  localparam int AmountBitsDefault  = 16;

  // Opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Command kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Wait count limits
  localparam logic signed [31:0] WAIT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WAIT_MIN = 32'sh8000_0000;

  // Input word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  command_kind;
    logic [15:0] command_amount;
    logic [15:0] elapsed_time;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [15:0] current_frame;
    logic        finished;
    logic        status;
  } out_word_t;

endpackage

// ===== rtl/fsq_table_mem.sv =====
// Command table: one write port, one read port with registered read data.
module fsq_table_mem
  import fsq_pkg::*;
#(
  parameter int DEPTH  = MaxCommandsDefault,
  parameter int DATA_W = 2 + AmountBitsDefault,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/fsq_wait_sat.sv =====
// Saturating signed add of a small delta to the 32-bit wait count.
module fsq_wait_sat
  import fsq_pkg::*;
(
  input  logic signed [31:0] count,
  input  logic signed [16:0] delta,
  output logic signed [31:0] result
);

  logic signed [32:0] sum;

  always_comb begin
    sum = 33'(count) + 33'(delta);
    // overflow when the two top bits disagree
    if (sum[32] != sum[31]) begin
      result = sum[32] ? WAIT_MIN : WAIT_MAX;
    end else begin
      result = sum[31:0];
    end
  end

endmodule

// ===== rtl/frame_script_sequencer.sv =====
// Top level of the frame script sequencer: control sequencer and result register.
//
// The block keeps a table of up to MAX_COMMANDS animation commands in a
// synchronous memory and runs it on tick words. One word is worked on at a
// time. Start, append, dead-tick and unused opcodes, and live ticks whose
// wait count stays non-negative, go from idle straight to the done state,
// where the output register takes their result word. A tick on a live,
// non-empty script whose wait count goes negative first passes through the
// exec state. The number of commands it executes is at most the program
// length, so at most MAX_COMMANDS. The memory read port delivers one
// command per cycle, and the next read is issued while the current command
// executes. The result register holds a finished word while out_stall is
// high, and a finished word waits in the done state until the register can
// take it. The block accepts a new word as soon as its sequencer is back in idle. No
// clearing pass follows reset: table entries are only read below the program
// length.
module frame_script_sequencer
  import fsq_pkg::*;
#(
  parameter int MAX_COMMANDS = MaxCommandsDefault,
  parameter int AMOUNT_BITS  = AmountBitsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // stored amount width: input field is 16 bits wide
  localparam int AB     = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
  localparam int IDX_W  = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int LEN_W  = $clog2(MAX_COMMANDS + 1);
  localparam int DATA_W = 2 + AB;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic signed [31:0] wc_r, wc_nxt;
  logic [AB-1:0]      frame_r, frame_nxt;
  logic               stopped_r, stopped_nxt;
  logic               status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;
  logic [1:0]         rd_kind;
  logic [AB-1:0]      rd_amount;

  logic signed [16:0] wu_delta;
  logic signed [31:0] wu_sum;
  logic signed [31:0] wc_after;

  logic [LEN_W-1:0]   pos_inc;
  logic [IDX_W-1:0]   pos_step;
  logic               load_out;

  // command table
  fsq_table_mem #(
    .DEPTH  (MAX_COMMANDS),
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len_r[IDX_W-1:0]),
    .wr_data ({in_word.command_kind, in_word.command_amount[AB-1:0]}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_kind   = rd_data[DATA_W-1 -: 2];
  assign rd_amount = rd_data[AB-1:0];

  // shared saturating wait-count adder
  fsq_wait_sat u_wait (
    .count  (wc_r),
    .delta  (wu_delta),
    .result (wu_sum)
  );

  // next position, wrapping at the program length
  assign pos_inc  = LEN_W'(pos_r) + LEN_W'(1);
  assign pos_step = (pos_inc == len_r) ? '0 : IDX_W'(pos_inc);

  // prefetch the next command while the current one executes
  assign rd_addr  = (state_r == S_EXEC) ? pos_step : pos_r;

  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    wc_nxt      = wc_r;
    frame_nxt   = frame_r;
    stopped_nxt = stopped_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    wu_delta    = '0;
    wc_after    = wc_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = 1'b0;
          state_nxt  = S_DONE;
          case (in_word.opcode)
            OP_START: begin
              len_nxt     = '0;
              pos_nxt     = '0;
              wc_nxt      = '0;
              frame_nxt   = '0;
              stopped_nxt = 1'b0;
            end
            OP_APPEND: begin
              if (len_r < LEN_W'(MAX_COMMANDS)) begin
                wr_en   = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end else begin
                status_nxt = 1'b1;
              end
            end
            OP_TICK: begin
              if (!stopped_r && (len_r != '0)) begin
                wu_delta  = -$signed({1'b0, in_word.elapsed_time});
                wc_nxt    = wu_sum;
                start_nxt = pos_r;
                if (wu_sum[31]) begin
                  state_nxt = S_EXEC;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_EXEC: begin
        pos_nxt = pos_step;
        case (rd_kind)
          KIND_FRAME: frame_nxt = rd_amount;
          KIND_WAIT: begin
            wu_delta = $signed({1'b0, 16'(rd_amount)});
            wc_after = wu_sum;
            wc_nxt   = wu_sum;
          end
          KIND_END: stopped_nxt = 1'b1;
          default: begin
          end
        endcase
        if ((rd_kind == KIND_END) || (pos_step == start_r) || !wc_after[31]) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.current_frame = 16'(frame_r);
      out_word_nxt.finished      = stopped_r;
      out_word_nxt.status        = status_r;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      wc_r        <= '0;
      frame_r     <= '0;
      stopped_r   <= 1'b1;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      wc_r        <= wc_nxt;
      frame_r     <= frame_nxt;
      stopped_r   <= stopped_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
